@@ rtl/isort_pkg.sv @@
// ----------------------------------------------------------------------------
// isort_pkg
// Shared constants, state encoding and the controller-to-datapath command.
// ----------------------------------------------------------------------------
package isort_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned DataW    = 16;
  localparam int unsigned CntW     = $clog2(CAPACITY + 1);

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_e;

  // insert: place value into the cell chain; shift: pop the head entry.
  typedef struct packed {
    logic            insert;
    logic            shift;
    logic [CntW-1:0] count;
  } cmd_t;

endpackage

@@ rtl/isort_dp.sv @@
// ----------------------------------------------------------------------------
// isort_dp
// Compare-and-shift cell chain holding the sorted set; head feeds the output.
// ----------------------------------------------------------------------------
module isort_dp (
  input  logic                                    clk_i,
  input  isort_pkg::cmd_t                         cmd_i,
  input  logic signed [isort_pkg::DataW-1:0]      value_i,
  output logic signed [isort_pkg::DataW-1:0]      head_o
);

  logic signed [isort_pkg::DataW-1:0] cell_q [isort_pkg::CAPACITY];
  logic signed [isort_pkg::DataW-1:0] cell_d [isort_pkg::CAPACITY];
  logic [isort_pkg::CAPACITY-1:0]     gt;

  // A cell moves up when it holds a strictly larger value or is unused.
  for (genvar i = 0; i < isort_pkg::CAPACITY; i++) begin : g_cell
    assign gt[i] = (isort_pkg::CntW'(i) >= cmd_i.count) || (cell_q[i] > value_i);

    always_comb begin
      cell_d[i] = cell_q[i];
      if (cmd_i.insert) begin
        if (gt[i]) begin
          if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
            cell_d[i] = cell_q[(i > 0) ? i - 1 : 0];
          end else begin
            cell_d[i] = value_i;
          end
        end
      end else if (cmd_i.shift) begin
        if (i < isort_pkg::CAPACITY - 1) begin
          cell_d[i] = cell_q[(i < isort_pkg::CAPACITY - 1) ? i + 1 : i];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      cell_q[i] <= cell_d[i];
    end
  end

  assign head_o = cell_q[0];

endmodule

@@ rtl/isort_ctrl.sv @@
// ----------------------------------------------------------------------------
// isort_ctrl
// Load/drain sequencer: tracks fill count and the sticky drop flag.
// ----------------------------------------------------------------------------
module isort_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             last_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             final_res_o,
  output logic             overflowed_o,
  output isort_pkg::cmd_t  cmd_o
);

  isort_pkg::state_e               state_q, state_d;
  logic [isort_pkg::CntW-1:0]      cnt_q, cnt_d;
  logic                            drop_q, drop_d;
  logic                            in_beat, out_beat, full, is_final;

  assign in_beat  = in_valid_i && (state_q == isort_pkg::ST_LOAD);
  assign out_beat = out_ready_i && (state_q == isort_pkg::ST_DRAIN);
  assign full     = (cnt_q == isort_pkg::CntW'(isort_pkg::CAPACITY));
  assign is_final = (cnt_q == isort_pkg::CntW'(1));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      isort_pkg::ST_LOAD: begin
        if (in_beat && last_i) state_d = isort_pkg::ST_DRAIN;
      end
      isort_pkg::ST_DRAIN: begin
        if (out_beat && is_final) state_d = isort_pkg::ST_LOAD;
      end
      default: state_d = isort_pkg::ST_LOAD;
    endcase
  end

  // Outputs and counters
  always_comb begin
    in_ready_o   = 1'b0;
    out_valid_o  = 1'b0;
    cmd_o.insert = 1'b0;
    cmd_o.shift  = 1'b0;
    cmd_o.count  = cnt_q;
    cnt_d        = cnt_q;
    drop_d       = drop_q;
    unique case (state_q)
      isort_pkg::ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_beat) begin
          if (full) begin
            drop_d = 1'b1;
          end else begin
            cmd_o.insert = 1'b1;
            cnt_d        = cnt_q + isort_pkg::CntW'(1);
          end
        end
      end
      isort_pkg::ST_DRAIN: begin
        out_valid_o = 1'b1;
        if (out_beat) begin
          cmd_o.shift = 1'b1;
          cnt_d       = cnt_q - isort_pkg::CntW'(1);
          if (is_final) drop_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign final_res_o  = is_final;
  assign overflowed_o = drop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= isort_pkg::ST_LOAD;
      cnt_q   <= '0;
      drop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      drop_q  <= drop_d;
    end
  end

endmodule

@@ rtl/insertion_sorter.sv @@
// Load: one input beat per cycle; each value lands in the cell chain in the cycle it is taken.
// Drain: starts the cycle after the last beat; one result per ready cycle, N for N stored.
// Input stalls while draining.
// The compare-and-shift cell chain sets the load rate; the head pop sets the drain rate.
// Reset (rst_ni low, async) empties the set and clears the drop flag; cells keep old data.
// ----------------------------------------------------------------------------
// insertion_sorter
// Stable insertion sorter for one set of signed 16-bit values, emitted
// in ascending order after the beat flagged last.
// ----------------------------------------------------------------------------
module insertion_sorter (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input channel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [isort_pkg::DataW-1:0]   value_i,
  input  logic                                 last_i,
  // result channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [isort_pkg::DataW-1:0]   sorted_value_o,
  output logic                                 final_res_o,
  output logic                                 overflowed_o
);

  isort_pkg::cmd_t cmd;

  // Controller: decide per cycle whether to insert, drop, or pop the head.
  isort_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .last_i       (last_i),
    .in_ready_o   (in_ready_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .final_res_o  (final_res_o),
    .overflowed_o (overflowed_o),
    .cmd_o        (cmd)
  );

  // Datapath: every cell compares against the new value in parallel, so
  // the whole insertion resolves in the cycle the beat is taken. The head cell is the
  // smallest stored value and drives the result payload directly.
  isort_dp u_dp (
    .clk_i   (clk_i),
    .cmd_i   (cmd),
    .value_i (value_i),
    .head_o  (sorted_value_o)
  );

  // Input and result sides never run at the same time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and result channels active together");

  // Results leave in ascending order within a set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !final_res_o) |=>
      (out_valid_o && (sorted_value_o >= $past(sorted_value_o))))
    else $error("result order broken");

  // After the final beat the block returns to loading.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && final_res_o) |=> (in_ready_o && !overflowed_o))
    else $error("no return to load after final result");

  // A last beat always leads to a drain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && last_i) |=> out_valid_o)
    else $error("no drain after last beat");

endmodule

@@ sim/isort_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// isort_checker
// Watches both channels of the insertion sorter. Keeps its own sorted set,
// queues the ascending run due after each beat flagged last, and compares
// every result beat field by field against the oldest queued entry.
// ----------------------------------------------------------------------------
module isort_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic signed [isort_pkg::DataW-1:0]  value_i,
  input  logic                                last_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic signed [isort_pkg::DataW-1:0]  sorted_value_i,
  input  logic                                final_res_i,
  input  logic                                overflowed_i,
  output int unsigned                         fail_cnt_o,
  output int unsigned                         due_cnt_o
);

  localparam int unsigned MaxShown = 10;

  typedef struct packed {
    logic signed [isort_pkg::DataW-1:0] val;
    logic                               fin;
    logic                               ovf;
  } sort_res_t;

  sort_res_t                          due_q[$];
  logic signed [isort_pkg::DataW-1:0] ladder [isort_pkg::CAPACITY];
  int unsigned                        held;
  bit                                 lost;

  initial begin
    fail_cnt_o = 0;
    due_cnt_o  = 0;
  end

  function automatic void note_fail(string msg);
    fail_cnt_o++;
    if (fail_cnt_o <= MaxShown) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endfunction

  // Insert one value stably; on the beat flagged last, queue the whole run.
  task automatic absorb_beat(input logic signed [isort_pkg::DataW-1:0] v, input logic l);
    int unsigned pos;
    sort_res_t   res;
    if (held < isort_pkg::CAPACITY) begin
      pos = held;
      // only strictly greater entries move up, so equal values keep arrival order
      while (pos > 0 && ladder[pos-1] > v) begin
        ladder[pos] = ladder[pos-1];
        pos--;
      end
      ladder[pos] = v;
      held++;
    end else begin
      lost = 1'b1;
    end
    if (l) begin
      for (int unsigned k = 0; k < held; k++) begin
        res.val = ladder[k];
        res.fin = (k + 1 == held);
        res.ovf = lost;
        due_q.push_back(res);
      end
      held = 0;
      lost = 1'b0;
    end
  endtask

  task automatic check_result();
    sort_res_t want;
    if (due_q.size() == 0) begin
      note_fail($sformatf("unexpected result value=%0d final=%0b ovf=%0b",
                          sorted_value_i, final_res_i, overflowed_i));
    end else begin
      want = due_q.pop_front();
      if (sorted_value_i !== want.val) begin
        note_fail($sformatf("sorted_value expected %0d got %0d", want.val, sorted_value_i));
      end
      if (final_res_i !== want.fin) begin
        note_fail($sformatf("final_res expected %0b got %0b (value %0d)",
                            want.fin, final_res_i, want.val));
      end
      if (overflowed_i !== want.ovf) begin
        note_fail($sformatf("overflowed expected %0b got %0b (value %0d)",
                            want.ovf, overflowed_i, want.val));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      due_q.delete();
      held = 0;
      lost = 1'b0;
    end else begin
      // results of a set can never share an edge with its own input beats
      if (out_valid_i && out_ready_i) begin
        check_result();
      end
      if (in_valid_i && in_ready_i) begin
        absorb_beat(value_i, last_i);
      end
    end
    due_cnt_o = due_q.size();
  end

endmodule

@@ sim/tb_insertion_sorter.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_insertion_sorter
// Drives sets of signed values into the insertion sorter with random gaps
// on the input and random back-pressure on the results, and leaves all
// prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module tb_insertion_sorter;

  localparam int unsigned HalfPeriod  = 6;
  localparam int unsigned ResetCycles = 9;
  // long receiver hold-off: long enough to fill a set and stall the input
  localparam int unsigned HoldCycles  = 200;
  // cycles without any beat before the run is declared hung
  localparam int unsigned StallLimit  = 3000;
  // settle time after the last expected result
  localparam int unsigned TailCycles  = 16;
  localparam int unsigned PhaseItems  = 80;

  logic                               clk_i       = 1'b0;
  logic                               rst_ni      = 1'b0;
  logic                               in_valid_i  = 1'b0;
  logic                               in_ready_o;
  logic signed [isort_pkg::DataW-1:0] value_i     = '0;
  logic                               last_i      = 1'b0;
  logic                               out_valid_o;
  logic                               out_ready_i = 1'b0;
  logic signed [isort_pkg::DataW-1:0] sorted_value_o;
  logic                               final_res_o;
  logic                               overflowed_o;

  int unsigned fail_cnt;
  int unsigned due_cnt;

  // idle chances in percent, changed per phase by the stimulus
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;

  // hold-off handshake between stimulus and receiver: bump hold_seq to request one
  int unsigned hold_seq  = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  int unsigned quiet_run = 0;

  always #(HalfPeriod) clk_i = ~clk_i;

  insertion_sorter dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .value_i        (value_i),
    .last_i         (last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sorted_value_o (sorted_value_o),
    .final_res_o    (final_res_o),
    .overflowed_o   (overflowed_o)
  );

  isort_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .value_i        (value_i),
    .last_i         (last_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sorted_value_i (sorted_value_o),
    .final_res_i    (final_res_o),
    .overflowed_i   (overflowed_o),
    .fail_cnt_o     (fail_cnt),
    .due_cnt_o      (due_cnt)
  );

  // Receiver: random back-pressure, or a solid hold-off when one is requested.
  always @(posedge clk_i) begin
    if (hold_seen != hold_seq) begin
      hold_seen = hold_seq;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Watchdog: end the run if no beat moves on either channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_run <= 0;
    end else if (quiet_run + 1 >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_run <= quiet_run + 1;
    end
  end

  // Offer one input beat; hold valid and payload until the beat is taken.
  // Valid only drops when an idle cycle is chosen, never between two beats.
  task automatic send_beat(input logic signed [isort_pkg::DataW-1:0] v, input logic l);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    last_i     <= l;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Draw a value: full range, a narrow band full of duplicates, or the extremes.
  function automatic logic signed [isort_pkg::DataW-1:0] pick_value(int unsigned flavor);
    logic signed [isort_pkg::DataW-1:0] v;
    int                                 d;
    v = isort_pkg::DataW'($urandom);
    if (flavor >= 50 && flavor < 75) begin
      d = $urandom_range(8);
      v = isort_pkg::DataW'(d - 4);
    end else if (flavor >= 75 && flavor < 90) begin
      case ($urandom_range(5))
        0:       v = 16'h8000;
        1:       v = 16'h7FFF;
        2:       v = 16'h0000;
        3:       v = 16'hFFFF;
        4:       v = 16'h0001;
        default: v = isort_pkg::DataW'($urandom);
      endcase
    end
    return v;
  endfunction

  // Send one set of n values with one value flavor; flag the final beat last.
  task automatic send_set(input int unsigned n);
    int unsigned flavor;
    flavor = $urandom_range(99);
    for (int unsigned i = 0; i < n; i++) begin
      send_beat(pick_value(flavor), i + 1 == n);
    end
  endtask

  // Random sets until about n_items beats went in. Most sets stay short;
  // a few come near or up to the store's capacity, and a few overrun it so values get dropped.
  task automatic send_random(input int unsigned n_items);
    int unsigned sent;
    int unsigned span;
    int unsigned r;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(99);
      if (r < 70) begin
        span = $urandom_range(8, 1);
      end else if (r < 90) begin
        span = $urandom_range(40, 9);
      end else if (r < 95) begin
        span = $urandom_range(isort_pkg::CAPACITY, isort_pkg::CAPACITY - 4);
      end else begin
        span = $urandom_range(isort_pkg::CAPACITY + 8, isort_pkg::CAPACITY + 1);
      end
      send_set(span);
      sent += span;
    end
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Phase 1: sender rarely idles, receiver mostly stalls.
    snd_idle_pct = 10;
    rcv_idle_pct = 88;

    // single-value set
    send_beat(16'sd5, 1'b1);
    // both extremes, zero and the values around it
    send_beat(16'h7FFF, 1'b0);
    send_beat(16'h8000, 1'b0);
    send_beat(16'h0000, 1'b0);
    send_beat(16'hFFFF, 1'b0);
    send_beat(16'h0001, 1'b1);
    // descending arrival: every insert shifts the whole set
    send_beat(16'sd300, 1'b0);
    send_beat(16'sd200, 1'b0);
    send_beat(16'sd100, 1'b0);
    send_beat(-16'sd100, 1'b0);
    send_beat(-16'sd300, 1'b1);
    // ascending arrival: no insert shifts anything
    send_beat(-16'sd3, 1'b0);
    send_beat(-16'sd2, 1'b0);
    send_beat(-16'sd1, 1'b0);
    send_beat(16'sd0, 1'b1);
    // repeated values must not disturb each other
    send_beat(16'sd7, 1'b0);
    send_beat(-16'sd7, 1'b0);
    send_beat(16'sd7, 1'b0);
    send_beat(-16'sd7, 1'b0);
    send_beat(16'sd7, 1'b1);

    send_random(PhaseItems);

    // Phase 2: sender mostly idles, receiver rarely stalls.
    snd_idle_pct = 88;
    rcv_idle_pct = 10;
    send_random(PhaseItems);

    // Phase 3: no idling. First hold off the receiver while a full set plus
    // a dropped last beat goes in, so the drain blocks and the input stalls.
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_seq++;
    send_set(isort_pkg::CAPACITY + 1);
    send_set(isort_pkg::CAPACITY + 6);
    send_random(PhaseItems);

    // Drop valid, then wait out every outstanding result.
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (due_cnt != 0);
    repeat (TailCycles) @(posedge clk_i);

    if (fail_cnt == 0 && due_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
